[hdl/hes_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// hes_pkg: shared types and constants of the histogram event sampler
// Field widths of the request and response beats, action codes and the
// saturation limit of the result counts.
// ---------------------------------------------------------------------------
package hes_pkg;

   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 12;
   localparam int LOAD_W   = 24;
   localparam int FRAC_W   = 32;
   localparam int COUNT_W  = 32;

   localparam int REQ_FIELDS_W = INDEX_W + LOAD_W + FRAC_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = INDEX_W + COUNT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD   = 2'd0,
      ACT_SAMPLE = 2'd1,
      ACT_READ   = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

endpackage
`default_nettype wire

[hdl/hes_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// hes_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module hes_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 4096,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hdl/hes_point.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// hes_point: sample point scaler
// Forms floor(frac * total / 2^32) with one 32x32 multiplier used twice,
// low half of the total first, then the high half; done pulses with point.
// ---------------------------------------------------------------------------
module hes_point
   import hes_pkg::*;
#(
   parameter int TOTAL_W = 36
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [FRAC_W-1:0]  frac,
   input  wire logic [TOTAL_W-1:0] total,
   output      logic [TOTAL_W-1:0] point,
   output      logic               done
);

   localparam int WIDE_W = 2 * FRAC_W;

   logic [2:0]         phase_ff;
   logic               done_ff;
   logic [FRAC_W-1:0]  frac_ff;
   logic [WIDE_W-1:0]  total_ff;
   logic [WIDE_W-1:0]  prod_ff;
   logic [FRAC_W-1:0]  carry_ff;
   logic [TOTAL_W-1:0] point_ff;

   logic [FRAC_W-1:0]  mul_b;
   logic [WIDE_W-1:0]  product;

   assign mul_b   = phase_ff[0] ? total_ff[FRAC_W-1:0] : total_ff[WIDE_W-1:FRAC_W];
   assign product = frac_ff * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= {phase_ff[1:0], start};
         done_ff  <= phase_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         frac_ff  <= frac;
         total_ff <= WIDE_W'(total);
      end
      if (phase_ff[0]) begin
         prod_ff <= product;
      end
      if (phase_ff[1]) begin
         // keep the integer part of the low product, then multiply the high half
         carry_ff <= prod_ff[WIDE_W-1:FRAC_W];
         prod_ff  <= product;
      end
      if (phase_ff[2]) begin
         point_ff <= TOTAL_W'(prod_ff + WIDE_W'(carry_ff));
      end
   end

   assign point = point_ff;
   assign done  = done_ff;

endmodule
`default_nettype wire

[hdl/histogram_event_sampler.sv]
`default_nettype none
// One request at a time; the sample time is set by the Fenwick tree descent,
// one tree memory read per level, and the load time by the tree update walk.
// Reset is synchronous; a clearing pass over every address zeroes both
// memories after reset, and no request is taken until it ends.
// ---------------------------------------------------------------------------
// histogram_event_sampler: inverse-transform event sampler
// Spectrum bins and result counts share one RAM; a Fenwick tree of partial
// spectrum sums in a second RAM serves the cumulative search.
// ---------------------------------------------------------------------------
module histogram_event_sampler
   import hes_pkg::*;
#(
   parameter int BIN_COUNT      = 4096,
   parameter int SPECTRUM_WIDTH = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // bin_index, bin_count, random_fraction
   input  wire logic [ACTION_W-1:0]    req_tuser,  // action
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [RSP_TDATA_W-1:0] rsp_tdata,  // bin_out, count_out
   output      logic                   rsp_tuser   // hit
);

   localparam int AW    = $clog2(BIN_COUNT);
   localparam int KW    = AW + 1;
   localparam int DEPTH = 1 << AW;
   localparam int SW    = SPECTRUM_WIDTH;
   localparam int TW    = SW + AW;
   localparam int BW    = COUNT_W + SW;
   localparam logic [AW-1:0] TOP_STEP = AW'(DEPTH / 2);

   typedef enum logic [9:0] {
      ST_INIT    = 10'b00_0000_0001,
      ST_IDLE    = 10'b00_0000_0010,
      ST_LD_READ = 10'b00_0000_0100,
      ST_FEN_UPD = 10'b00_0000_1000,
      ST_RD_READ = 10'b00_0001_0000,
      ST_SCALE   = 10'b00_0010_0000,
      ST_SEARCH  = 10'b00_0100_0000,
      ST_BUMP    = 10'b00_1000_0000,
      ST_CLEAR   = 10'b01_0000_0000,
      ST_RESP    = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [KW-1:0]      addr_ff, addr_in;
   logic [TW-1:0]      total_ff, total_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [SW-1:0]      load_ff, load_in;
   logic [TW-1:0]      delta_ff, delta_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [TW-1:0]      rem_ff, rem_in;
   logic [AW-1:0]      step_ff, step_in;
   logic [INDEX_W-1:0] res_bin_ff, res_bin_in;
   logic [COUNT_W-1:0] res_count_ff, res_count_in;
   logic               res_hit_ff, res_hit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_bin_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_hit_ff;

   logic [INDEX_W-1:0] req_index;
   logic [LOAD_W-1:0]  req_load;
   logic [FRAC_W-1:0]  req_frac;
   action_type         req_action;
   logic               req_fire;
   logic               req_in_range;

   logic               bin_wr_en, bin_rd_en;
   logic [AW-1:0]      bin_wr_addr, bin_rd_addr;
   logic [BW-1:0]      bin_wr_data, bin_rd_data;
   logic               tree_wr_en, tree_rd_en;
   logic [AW-1:0]      tree_wr_addr, tree_rd_addr;
   logic [TW-1:0]      tree_wr_data, tree_rd_data;

   logic               point_start, point_done;
   logic [TW-1:0]      point;

   logic [SW-1:0]      old_spec;
   logic [COUNT_W-1:0] old_hist;
   logic [COUNT_W-1:0] bumped;
   logic [TW-1:0]      ld_delta;
   logic [KW-1:0]      ld_node;
   logic [KW-1:0]      fen_next;
   logic [KW-1:0]      sweep_next;
   logic               take;
   logic [AW-1:0]      pos_take;
   logic               out_free;
   logic               load_out;

   assign req_index    = req_tdata[INDEX_W-1:0];
   assign req_load     = req_tdata[INDEX_W +: LOAD_W];
   assign req_frac     = req_tdata[INDEX_W+LOAD_W +: FRAC_W];
   assign req_action   = action_type'(req_tuser);
   assign req_tready   = (state_ff == ST_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign req_in_range = 32'(req_index) < BIN_COUNT;

   assign old_spec   = bin_rd_data[SW-1:0];
   assign old_hist   = bin_rd_data[BW-1:SW];
   assign bumped     = (old_hist == COUNT_MAX) ? old_hist : old_hist + COUNT_W'(1);
   assign ld_delta   = TW'(load_ff) - TW'(old_spec);
   assign ld_node    = KW'(idx_ff) + KW'(1);
   // next tree node upward: add the lowest set bit
   assign fen_next   = addr_ff + (addr_ff & (~addr_ff + KW'(1)));
   assign sweep_next = addr_ff + KW'(1);
   assign take       = tree_rd_data <= rem_ff;
   assign pos_take   = take ? (pos_ff | step_ff) : pos_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign load_out   = (state_ff == ST_RESP) && out_free;

   hes_ram #(
      .WIDTH (BW),
      .DEPTH (DEPTH)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (bin_wr_en),
      .wr_addr (bin_wr_addr),
      .wr_data (bin_wr_data),
      .rd_en   (bin_rd_en),
      .rd_addr (bin_rd_addr),
      .rd_data (bin_rd_data)
   );

   // tree node k lives at address k mod DEPTH, so the root sits at address zero
   hes_ram #(
      .WIDTH (TW),
      .DEPTH (DEPTH)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (tree_wr_en),
      .wr_addr (tree_wr_addr),
      .wr_data (tree_wr_data),
      .rd_en   (tree_rd_en),
      .rd_addr (tree_rd_addr),
      .rd_data (tree_rd_data)
   );

   hes_point #(
      .TOTAL_W (TW)
   ) u_point (
      .clock (clock),
      .reset (reset),
      .start (point_start),
      .frac  (req_frac),
      .total (total_ff),
      .point (point),
      .done  (point_done)
   );

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      load_in      = load_ff;
      delta_in     = delta_ff;
      pos_in       = pos_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      res_bin_in   = res_bin_ff;
      res_count_in = res_count_ff;
      res_hit_in   = res_hit_ff;
      point_start  = 1'b0;
      bin_wr_en    = 1'b0;
      bin_wr_addr  = addr_ff[AW-1:0];
      bin_wr_data  = '0;
      bin_rd_en    = 1'b0;
      bin_rd_addr  = AW'(idx_ff);
      tree_wr_en   = 1'b0;
      tree_wr_addr = addr_ff[AW-1:0];
      tree_wr_data = '0;
      tree_rd_en   = 1'b0;
      tree_rd_addr = addr_ff[AW-1:0];

      unique case (state_ff)
         ST_INIT: begin
            bin_wr_en  = 1'b1;
            tree_wr_en = 1'b1;
            addr_in    = sweep_next;
            if (&addr_ff[AW-1:0]) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               idx_in  = req_index;
               load_in = SW'(req_load);
               unique case (req_action)
                  ACT_LOAD, ACT_READ: begin
                     if (req_in_range) begin
                        bin_rd_en   = 1'b1;
                        bin_rd_addr = AW'(req_index);
                        state_in    = (req_action == ACT_LOAD) ? ST_LD_READ : ST_RD_READ;
                     end else begin
                        res_bin_in   = req_index;
                        res_count_in = '0;
                        res_hit_in   = 1'b0;
                        state_in     = ST_RESP;
                     end
                  end
                  ACT_SAMPLE: begin
                     if (total_ff == '0) begin
                        res_bin_in   = '0;
                        res_count_in = '0;
                        res_hit_in   = 1'b0;
                        state_in     = ST_RESP;
                     end else begin
                        point_start = 1'b1;
                        state_in    = ST_SCALE;
                     end
                  end
                  ACT_CLEAR: begin
                     bin_rd_en   = 1'b1;
                     bin_rd_addr = '0;
                     addr_in     = '0;
                     state_in    = ST_CLEAR;
                  end
               endcase
            end
         end
         ST_LD_READ: begin
            bin_wr_en    = 1'b1;
            bin_wr_addr  = AW'(idx_ff);
            bin_wr_data  = {old_hist, load_ff};
            delta_in     = ld_delta;
            total_in     = total_ff + ld_delta;
            res_bin_in   = idx_ff;
            res_count_in = old_hist;
            res_hit_in   = 1'b1;
            addr_in      = ld_node;
            tree_rd_en   = 1'b1;
            tree_rd_addr = ld_node[AW-1:0];
            state_in     = ST_FEN_UPD;
         end
         ST_FEN_UPD: begin
            tree_wr_en   = 1'b1;
            tree_wr_data = tree_rd_data + delta_ff;
            // the walk always ends at the root node
            if (addr_ff[AW]) begin
               state_in = ST_RESP;
            end else begin
               addr_in      = fen_next;
               tree_rd_en   = 1'b1;
               tree_rd_addr = fen_next[AW-1:0];
            end
         end
         ST_RD_READ: begin
            res_bin_in   = idx_ff;
            res_count_in = old_hist;
            res_hit_in   = 1'b1;
            state_in     = ST_RESP;
         end
         ST_SCALE: begin
            if (point_done) begin
               pos_in       = '0;
               rem_in       = point;
               step_in      = TOP_STEP;
               tree_rd_en   = 1'b1;
               tree_rd_addr = TOP_STEP;
               state_in     = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            pos_in = pos_take;
            rem_in = take ? rem_ff - tree_rd_data : rem_ff;
            if (step_ff[0]) begin
               bin_rd_en   = 1'b1;
               bin_rd_addr = pos_take;
               state_in    = ST_BUMP;
            end else begin
               step_in      = step_ff >> 1;
               tree_rd_en   = 1'b1;
               tree_rd_addr = pos_take | (step_ff >> 1);
            end
         end
         ST_BUMP: begin
            bin_wr_en    = 1'b1;
            bin_wr_addr  = pos_ff;
            bin_wr_data  = {bumped, old_spec};
            res_bin_in   = INDEX_W'(pos_ff);
            res_count_in = bumped;
            res_hit_in   = 1'b1;
            state_in     = ST_RESP;
         end
         ST_CLEAR: begin
            // drop the count, keep the spectrum bin
            bin_wr_en   = 1'b1;
            bin_wr_data = {COUNT_W'(0), old_spec};
            if (&addr_ff[AW-1:0]) begin
               addr_in      = '0;
               res_bin_in   = '0;
               res_count_in = '0;
               res_hit_in   = 1'b1;
               state_in     = ST_RESP;
            end else begin
               addr_in     = sweep_next;
               bin_rd_en   = 1'b1;
               bin_rd_addr = sweep_next[AW-1:0];
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         addr_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      load_ff      <= load_in;
      delta_ff     <= delta_in;
      pos_ff       <= pos_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      res_bin_ff   <= res_bin_in;
      res_count_ff <= res_count_in;
      res_hit_ff   <= res_hit_in;
      if (load_out) begin
         rsp_bin_ff   <= res_bin_ff;
         rsp_count_ff <= res_count_ff;
         rsp_hit_ff   <= res_hit_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_count_ff, rsp_bin_ff});
   assign rsp_tuser  = rsp_hit_ff;

   a_search_needs_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (total_ff != '0))
      else $error("tree search running on an empty spectrum");

   a_search_step_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> $onehot(step_ff))
      else $error("search step lost its single bit");

   a_fen_node_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FEN_UPD) |-> ((addr_ff != '0) && (32'(addr_ff) <= DEPTH)))
      else $error("tree update node outside the tree");

   a_found_bin_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUMP) |-> (32'(pos_ff) < BIN_COUNT))
      else $error("sample landed beyond the last bin");

endmodule
`default_nettype wire
